// ===== hw/rtl/mctc_pkg.sv =====
// ----------------------------------------------------------------------------
// mctc_pkg
// Shared widths, operation and status codes for the Morse code table codec.
// ----------------------------------------------------------------------------
package mctc_pkg;

	localparam int MAX_CODE_LENGTH = 8;

	localparam int MODE_W   = 2;
	localparam int CHAR_W   = 8;
	localparam int CODE_W   = 8;
	localparam int LEN_W    = 4;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = LEN_W + CODE_W;
	localparam int CHAR_COUNT = 1 << CHAR_W;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

endpackage

// ===== hw/rtl/mctc_ram.sv =====
// ----------------------------------------------------------------------------
// mctc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mctc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/morse_code_table_codec.sv =====
// ----------------------------------------------------------------------------
// morse_code_table_codec
// Loadable Morse code table with its binary code tree: insert, encode, decode.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  request   in         start & !busy        mode, character, code_bits, code_length
//  result    out        done (one cycle)     result_char, result_code,
//                                            result_length, status
//
//  From the accepting edge to the edge that raises done: insert writes one
//    tree node per symbol of the code length saturated to MAX_CODE_LENGTH
//    (the root for an empty code); encode looks up the key, then reads the
//    code RAM unless it is unknown; decode reads the node RAM then checks it
//    per symbol walked, ending early at a missing node. Empty decode and the
//    unused mode raise done on the accepting edge; busy is low in the result beat.
//  After reset the block sweeps all 2^(MAX_CODE_LENGTH+1)-1 entries (511 at
//  the default) of both node RAMs, one entry a cycle, with busy held high.
//  The receiver cannot stall: done marks a result for exactly one cycle.
//
// ----------------------------------------------------------------------------
module morse_code_table_codec #(
	parameter int MAX_CODE_LENGTH = mctc_pkg::MAX_CODE_LENGTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [mctc_pkg::MODE_W-1:0]   mode,
	input  logic [mctc_pkg::CHAR_W-1:0]   character,
	input  logic [mctc_pkg::CODE_W-1:0]   code_bits,
	input  logic [mctc_pkg::LEN_W-1:0]    code_length,
	output logic                          done,
	output logic [mctc_pkg::CHAR_W-1:0]   result_char,
	output logic [mctc_pkg::CODE_W-1:0]   result_code,
	output logic [mctc_pkg::LEN_W-1:0]    result_length,
	output logic [mctc_pkg::STATUS_W-1:0] status
);

	// Heap-numbered tree: root 1, children 2h (dot) and 2h+1 (dash), entry h-1.
	localparam int NODE_W     = MAX_CODE_LENGTH + 1;
	localparam int NODE_COUNT = (1 << NODE_W) - 1;
	localparam int LEN_W      = mctc_pkg::LEN_W;
	localparam int CHAR_W     = mctc_pkg::CHAR_W;
	localparam int CODE_W     = mctc_pkg::CODE_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INSERT,
		S_ENC_LOOK,
		S_ENC_READ,
		S_DEC_READ,
		S_DEC_CHECK
	} state_t;

	state_t state_q;

	logic [NODE_W-1:0]   clr_q;     // clearing sweep address
	logic [NODE_W-1:0]   h_q;       // current tree node
	logic [LEN_W-1:0]    rem_q;     // symbols still to walk
	logic [LEN_W-1:0]    len_q;
	logic [CHAR_W-1:0]   ch_q;
	logic [CODE_W-1:0]   bits_q;
	logic [mctc_pkg::CHAR_COUNT-1:0] known_q;

	logic                          done_q;
	logic [CHAR_W-1:0]             result_char_q;
	logic [CODE_W-1:0]             result_code_q;
	logic [LEN_W-1:0]              result_length_q;
	logic [mctc_pkg::STATUS_W-1:0] status_q;

	// Effective length of the incoming request.
	logic [LEN_W-1:0] len_in;
	assign len_in = (code_length > LEN_W'(MAX_CODE_LENGTH)) ?
	                LEN_W'(MAX_CODE_LENGTH) : code_length;

	// Next symbol: position rem-1, positions above the code byte read as dots.
	logic [LEN_W-1:0]  pos;
	logic              sym;
	logic [NODE_W-1:0] h_next;
	logic [NODE_W-1:0] node_addr;
	assign pos       = rem_q - LEN_W'(1);
	assign sym       = (pos < LEN_W'(CODE_W)) ? bits_q[pos[2:0]] : 1'b0;
	assign h_next    = {h_q[NODE_W-2:0], sym};
	assign node_addr = h_next - NODE_W'(1);

	// Encode key: retry with the lowercase form of an unknown capital.
	logic [CHAR_W-1:0] key;
	logic              key_hit;
	always_comb begin
		key = ch_q;
		if (!known_q[ch_q] && ch_q >= mctc_pkg::CHAR_UPPER_A &&
		    ch_q <= mctc_pkg::CHAR_UPPER_Z) begin
			key = ch_q + mctc_pkg::CASE_OFFSET;
		end
		key_hit = known_q[key];
	end

	// RAM ports
	logic                    pres_we;
	logic [NODE_W-1:0]       pres_waddr;
	logic [0:0]              pres_wdata;
	logic [0:0]              pres_rdata;
	logic                    lett_we;
	logic [NODE_W-1:0]       lett_waddr;
	logic [CHAR_W-1:0]       lett_wdata;
	logic [CHAR_W-1:0]       lett_rdata;
	logic                    code_we;
	logic [mctc_pkg::ENTRY_W-1:0] code_rdata;
	logic                    ins_last;

	assign ins_last = (rem_q == LEN_W'(0)) || (rem_q == LEN_W'(1));

	always_comb begin
		pres_we    = 1'b0;
		pres_waddr = node_addr;
		pres_wdata = 1'b1;
		lett_we    = 1'b0;
		lett_waddr = node_addr;
		lett_wdata = ch_q;
		code_we    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				pres_we    = 1'b1;
				pres_waddr = clr_q;
				pres_wdata = 1'b0;
				lett_we    = 1'b1;
				lett_waddr = clr_q;
				lett_wdata = '0;
			end
			S_INSERT: begin
				code_we = 1'b1;
				pres_we = (len_q != LEN_W'(0));
				lett_we = ins_last;
				// an empty code parks the character at the root
				if (len_q == LEN_W'(0)) begin
					lett_waddr = h_q - NODE_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	mctc_ram #(
		.WIDTH(1),
		.DEPTH(NODE_COUNT)
	) u_present_ram (
		.clk   (clk),
		.we    (pres_we),
		.waddr (pres_waddr),
		.wdata (pres_wdata),
		.raddr (node_addr),
		.rdata (pres_rdata)
	);

	mctc_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(NODE_COUNT)
	) u_letter_ram (
		.clk   (clk),
		.we    (lett_we),
		.waddr (lett_waddr),
		.wdata (lett_wdata),
		.raddr (node_addr),
		.rdata (lett_rdata)
	);

	mctc_ram #(
		.WIDTH(mctc_pkg::ENTRY_W),
		.DEPTH(mctc_pkg::CHAR_COUNT)
	) u_code_ram (
		.clk   (clk),
		.we    (code_we),
		.waddr (ch_q),
		.wdata ({len_q, bits_q}),
		.raddr (key),
		.rdata (code_rdata)
	);

	// Sequencer and registered result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_q           <= '0;
			h_q             <= NODE_W'(1);
			rem_q           <= '0;
			len_q           <= '0;
			ch_q            <= '0;
			bits_q          <= '0;
			known_q         <= '0;
			done_q          <= 1'b0;
			result_char_q   <= '0;
			result_code_q   <= '0;
			result_length_q <= '0;
			status_q        <= mctc_pkg::STATUS_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						ch_q            <= character;
						bits_q          <= code_bits;
						len_q           <= len_in;
						rem_q           <= len_in;
						h_q             <= NODE_W'(1);
						result_char_q   <= '0;
						result_code_q   <= '0;
						result_length_q <= '0;
						status_q        <= mctc_pkg::STATUS_OK;
						case (mode)
							mctc_pkg::MODE_INSERT: state_q <= S_INSERT;
							mctc_pkg::MODE_ENCODE: state_q <= S_ENC_LOOK;
							mctc_pkg::MODE_DECODE: begin
								if (len_in == LEN_W'(0)) begin
									status_q <= mctc_pkg::STATUS_EMPTY;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_DEC_READ;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_INSERT: begin
					known_q[ch_q] <= 1'b1;
					if (ins_last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						h_q   <= h_next;
						rem_q <= pos;
					end
				end
				S_ENC_LOOK: begin
					if (key_hit) begin
						state_q <= S_ENC_READ;
					end else begin
						status_q <= mctc_pkg::STATUS_NOT_FOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_ENC_READ: begin
					result_code_q   <= code_rdata[CODE_W-1:0];
					result_length_q <= code_rdata[mctc_pkg::ENTRY_W-1:CODE_W];
					done_q          <= 1'b1;
					state_q         <= S_IDLE;
				end
				S_DEC_READ: begin
					h_q     <= h_next;
					rem_q   <= pos;
					state_q <= S_DEC_CHECK;
				end
				S_DEC_CHECK: begin
					if (!pres_rdata[0]) begin
						status_q <= mctc_pkg::STATUS_NOT_FOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (rem_q == LEN_W'(0)) begin
						result_char_q <= lett_rdata;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_DEC_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign result_char   = result_char_q;
	assign result_code   = result_code_q;
	assign result_length = result_length_q;
	assign status        = status_q;

endmodule
